FILE: hw/rtl/mvd_pkg.sv
// Package for the mesh vertex dedup unit: store sizes, field widths, codes,
// state type, RAM request structs and the IEEE word compare.
// No dependencies.
`default_nettype none

package mvd_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int MAX_TEXCOORDS = 1024;
  localparam int MAX_NORMALS   = 1024;
  localparam int MAX_UNIQUE    = 1024;

  localparam int POS_AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int TEX_AW = (MAX_TEXCOORDS > 1) ? $clog2(MAX_TEXCOORDS) : 1;
  localparam int NRM_AW = (MAX_NORMALS > 1) ? $clog2(MAX_NORMALS) : 1;
  localparam int UNQ_AW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;

  localparam int POS_CW = $clog2(MAX_POSITIONS + 1);
  localparam int TEX_CW = $clog2(MAX_TEXCOORDS + 1);
  localparam int NRM_CW = $clog2(MAX_NORMALS + 1);
  localparam int UNQ_CW = $clog2(MAX_UNIQUE + 1);

  localparam int KIND_W   = 2;
  localparam int WORD_W   = 32;
  localparam int REF_W    = 11;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;

  localparam int POS_DW  = 3 * WORD_W;
  localparam int TEX_DW  = 2 * WORD_W;
  localparam int NRM_DW  = 3 * WORD_W;
  localparam int VERT_WORDS = 8;
  localparam int VERT_DW = VERT_WORDS * WORD_W;

  localparam logic [KIND_W-1:0] KIND_POS    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UV     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NRM    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CORNER = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BADREF = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FETCH,
    ST_SCAN,
    ST_INSERT,
    ST_RESP
  } mvd_state_t;

  typedef struct packed {
    logic              we;
    logic [POS_AW-1:0] waddr;
    logic [POS_DW-1:0] wdata;
    logic [POS_AW-1:0] raddr;
  } pos_req_t;

  typedef struct packed {
    logic              we;
    logic [TEX_AW-1:0] waddr;
    logic [TEX_DW-1:0] wdata;
    logic [TEX_AW-1:0] raddr;
  } tex_req_t;

  typedef struct packed {
    logic              we;
    logic [NRM_AW-1:0] waddr;
    logic [NRM_DW-1:0] wdata;
    logic [NRM_AW-1:0] raddr;
  } nrm_req_t;

  typedef struct packed {
    logic               we;
    logic [UNQ_AW-1:0]  waddr;
    logic [VERT_DW-1:0] wdata;
    logic [UNQ_AW-1:0]  raddr;
  } unq_req_t;

  typedef struct packed {
    logic              busy;
    logic [UNQ_CW-1:0] unique_count;
  } mvd_stat_t;

  function automatic logic word_is_nan(logic [WORD_W-1:0] w);
    return (w[WORD_W-2:0] > 31'h7F80_0000);
  endfunction

  // IEEE equality on binary32 bit patterns: signed zeros match, NaN never
  function automatic logic words_equal(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] both;
    both = a | b;
    if (word_is_nan(a) || word_is_nan(b)) begin
      return 1'b0;
    end
    if (both[WORD_W-2:0] == '0) begin
      return 1'b1;
    end
    return (a == b);
  endfunction

  function automatic logic vert_equal(logic [VERT_DW-1:0] a, logic [VERT_DW-1:0] b);
    logic eq;
    eq = 1'b1;
    for (int k = 0; k < VERT_WORDS; k++) begin
      eq = eq & words_equal(a[k*WORD_W +: WORD_W], b[k*WORD_W +: WORD_W]);
    end
    return eq;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mvd_in_if.sv
// Input channel of the mesh vertex dedup unit: valid/ready and one item.
// Depends on mvd_pkg.
`default_nettype none

interface mvd_in_if import mvd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [WORD_W-1:0]    coord_x;
  logic [WORD_W-1:0]    coord_y;
  logic [WORD_W-1:0]    coord_z;
  logic [REF_W-1:0]     position_ref;
  logic [REF_W-1:0]     texcoord_ref;
  logic [REF_W-1:0]     normal_ref;

  modport source (
    output valid, kind, coord_x, coord_y, coord_z, position_ref, texcoord_ref, normal_ref,
    input  ready
  );

  modport sink (
    input  valid, kind, coord_x, coord_y, coord_z, position_ref, texcoord_ref, normal_ref,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/mvd_out_if.sv
// Result channel of the mesh vertex dedup unit: valid/ready and one result.
// Depends on mvd_pkg.
`default_nettype none

interface mvd_out_if import mvd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   vertex_slot;
  logic                created;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, vertex_slot, created, status,
    input  ready
  );

  modport sink (
    input  valid, vertex_slot, created, status,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/mvd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mvd_ram #(
  parameter  int DW    = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mvd_ctrl.sv
// Sequencer of the mesh vertex dedup unit: item capture, attribute appends,
// corner fetch, unique-table scan and insert, result register.
// Depends on mvd_pkg, mvd_in_if, mvd_out_if.
`default_nettype none

module mvd_ctrl import mvd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mvd_in_if.sink             in_ch,
  mvd_out_if.source          out_ch,
  output pos_req_t           pos_req,
  input  wire logic [POS_DW-1:0]  pos_rd,
  output tex_req_t           tex_req,
  input  wire logic [TEX_DW-1:0]  tex_rd,
  output nrm_req_t           nrm_req,
  input  wire logic [NRM_DW-1:0]  nrm_rd,
  output unq_req_t           unq_req,
  input  wire logic [VERT_DW-1:0] unq_rd,
  output mvd_stat_t          stat
);

  mvd_state_t state_r, state_nxt;

  // captured item
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [WORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [REF_W-1:0]  pr_r, pr_nxt, tr_r, tr_nxt, nr_r, nr_nxt;

  logic [POS_CW-1:0] pos_cnt_r, pos_cnt_nxt;
  logic [TEX_CW-1:0] tex_cnt_r, tex_cnt_nxt;
  logic [NRM_CW-1:0] nrm_cnt_r, nrm_cnt_nxt;
  logic [UNQ_CW-1:0] unq_cnt_r, unq_cnt_nxt;

  logic [UNQ_AW-1:0]  scan_idx_r, scan_idx_nxt;
  logic [VERT_DW-1:0] vert_r, vert_nxt;

  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                res_created_r, res_created_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_created_r, out_created_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic pos_full, tex_full, nrm_full, unq_full;
  logic refs_ok, scan_hit, scan_last, out_free, take;

  assign pos_full = (pos_cnt_r == POS_CW'(MAX_POSITIONS));
  assign tex_full = (tex_cnt_r == TEX_CW'(MAX_TEXCOORDS));
  assign nrm_full = (nrm_cnt_r == NRM_CW'(MAX_NORMALS));
  assign unq_full = (unq_cnt_r == UNQ_CW'(MAX_UNIQUE));

  assign refs_ok = (pr_r != '0) && (32'(pr_r) <= 32'(pos_cnt_r)) &&
                   (tr_r != '0) && (32'(tr_r) <= 32'(tex_cnt_r)) &&
                   (nr_r != '0) && (32'(nr_r) <= 32'(nrm_cnt_r));

  // unq_rd holds the entry at scan_idx_r while scanning
  assign scan_hit  = vert_equal(vert_r, unq_rd);
  assign scan_last = ((UNQ_CW'(scan_idx_r) + UNQ_CW'(1)) == unq_cnt_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign take      = (state_r == ST_IDLE) && in_ch.valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (kind_r)
          KIND_POS:    state_nxt = pos_full ? ST_RESP : ST_IDLE;
          KIND_UV:     state_nxt = tex_full ? ST_RESP : ST_IDLE;
          KIND_NRM:    state_nxt = nrm_full ? ST_RESP : ST_IDLE;
          KIND_CORNER: state_nxt = refs_ok ? ST_FETCH : ST_RESP;
        endcase
      end
      ST_FETCH: begin
        state_nxt = (unq_cnt_r == '0) ? ST_INSERT : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = ST_RESP;
        end else if (scan_last) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    kind_nxt        = kind_r;
    cx_nxt          = cx_r;
    cy_nxt          = cy_r;
    cz_nxt          = cz_r;
    pr_nxt          = pr_r;
    tr_nxt          = tr_r;
    nr_nxt          = nr_r;
    pos_cnt_nxt     = pos_cnt_r;
    tex_cnt_nxt     = tex_cnt_r;
    nrm_cnt_nxt     = nrm_cnt_r;
    unq_cnt_nxt     = unq_cnt_r;
    scan_idx_nxt    = scan_idx_r;
    vert_nxt        = vert_r;
    res_slot_nxt    = res_slot_r;
    res_created_nxt = res_created_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_slot_nxt    = out_slot_r;
    out_created_nxt = out_created_r;
    out_status_nxt  = out_status_r;

    pos_req.we    = 1'b0;
    pos_req.waddr = POS_AW'(pos_cnt_r);
    pos_req.wdata = {cz_r, cy_r, cx_r};
    pos_req.raddr = POS_AW'(pr_r - REF_W'(1));
    tex_req.we    = 1'b0;
    tex_req.waddr = TEX_AW'(tex_cnt_r);
    tex_req.wdata = {cy_r, cx_r};
    tex_req.raddr = TEX_AW'(tr_r - REF_W'(1));
    nrm_req.we    = 1'b0;
    nrm_req.waddr = NRM_AW'(nrm_cnt_r);
    nrm_req.wdata = {cz_r, cy_r, cx_r};
    nrm_req.raddr = NRM_AW'(nr_r - REF_W'(1));
    unq_req.we    = 1'b0;
    unq_req.waddr = UNQ_AW'(unq_cnt_r);
    unq_req.wdata = vert_r;
    unq_req.raddr = scan_idx_r + UNQ_AW'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          kind_nxt = in_ch.kind;
          cx_nxt   = in_ch.coord_x;
          cy_nxt   = in_ch.coord_y;
          cz_nxt   = in_ch.coord_z;
          pr_nxt   = in_ch.position_ref;
          tr_nxt   = in_ch.texcoord_ref;
          nr_nxt   = in_ch.normal_ref;
        end
      end
      ST_DISPATCH: begin
        res_slot_nxt    = '0;
        res_created_nxt = 1'b0;
        res_status_nxt  = STAT_FULL;
        unique case (kind_r)
          KIND_POS: begin
            if (!pos_full) begin
              pos_req.we  = 1'b1;
              pos_cnt_nxt = pos_cnt_r + POS_CW'(1);
            end
          end
          KIND_UV: begin
            if (!tex_full) begin
              tex_req.we  = 1'b1;
              tex_cnt_nxt = tex_cnt_r + TEX_CW'(1);
            end
          end
          KIND_NRM: begin
            if (!nrm_full) begin
              nrm_req.we  = 1'b1;
              nrm_cnt_nxt = nrm_cnt_r + NRM_CW'(1);
            end
          end
          KIND_CORNER: begin
            res_status_nxt = STAT_BADREF;
          end
        endcase
      end
      ST_FETCH: begin
        // layout: position x,y,z, normal x,y,z, u, v
        vert_nxt      = {tex_rd, nrm_rd, pos_rd};
        scan_idx_nxt  = '0;
        unq_req.raddr = '0;
      end
      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + UNQ_AW'(1);
        if (scan_hit) begin
          res_slot_nxt    = SLOT_W'(scan_idx_r);
          res_created_nxt = 1'b0;
          res_status_nxt  = STAT_OK;
        end
      end
      ST_INSERT: begin
        if (unq_full) begin
          res_slot_nxt    = '0;
          res_created_nxt = 1'b0;
          res_status_nxt  = STAT_FULL;
        end else begin
          unq_req.we      = 1'b1;
          unq_cnt_nxt     = unq_cnt_r + UNQ_CW'(1);
          res_slot_nxt    = SLOT_W'(unq_cnt_r);
          res_created_nxt = 1'b1;
          res_status_nxt  = STAT_OK;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_slot_nxt    = res_slot_r;
          out_created_nxt = res_created_r;
          out_status_nxt  = res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_cnt_r   <= '0;
      tex_cnt_r   <= '0;
      nrm_cnt_r   <= '0;
      unq_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_cnt_r   <= pos_cnt_nxt;
      tex_cnt_r   <= tex_cnt_nxt;
      nrm_cnt_r   <= nrm_cnt_nxt;
      unq_cnt_r   <= unq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    cx_r          <= cx_nxt;
    cy_r          <= cy_nxt;
    cz_r          <= cz_nxt;
    pr_r          <= pr_nxt;
    tr_r          <= tr_nxt;
    nr_r          <= nr_nxt;
    scan_idx_r    <= scan_idx_nxt;
    vert_r        <= vert_nxt;
    res_slot_r    <= res_slot_nxt;
    res_created_r <= res_created_nxt;
    res_status_r  <= res_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_created_r <= out_created_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.vertex_slot = out_slot_r;
  assign out_ch.created     = out_created_r;
  assign out_ch.status      = out_status_r;

  assign stat.busy         = (state_r != ST_IDLE);
  assign stat.unique_count = unq_cnt_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mesh_vertex_dedup_unit.sv
// Top level of the mesh vertex dedup unit: attribute and unique-vertex RAMs,
// sequencer and checks. Depends on mvd_pkg, mvd_in_if, mvd_out_if, mvd_ram, mvd_ctrl.
//
// Usage:
//   in_ch carries one item per transaction: kind 0/1/2 appends a position, uv
//   or normal; kind 3 is a corner with one-based position, uv and normal refs.
//   out_ch returns one result (vertex_slot, created, status) per corner, and
//   one per append that hits a full store (status full). Good appends return
//   nothing.
//   Flow: an append is accepted, then written to its store. A corner reads its
//   attributes, then scans N unique vertices, N being those compared before a hit
//   or the unique count on a miss: the scan reads one unique-store entry per
//   cycle from its single read port. A bad reference is answered without a scan.
//   One item is worked on at a time; in_ch.ready is high when the sequencer
//   is idle.
//   Reset clears the four counts, the state and the output valid only; the
//   stores need no clearing pass, since only written entries are ever used.
//   Stall: a result sits in the output register while out_ch.ready is low and
//   the next item is still accepted; its own result waits until the register
//   frees up.
`default_nettype none

module mesh_vertex_dedup_unit import mvd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mvd_in_if.sink    in_ch,
  mvd_out_if.source out_ch
);

  pos_req_t  pos_req;
  tex_req_t  tex_req;
  nrm_req_t  nrm_req;
  unq_req_t  unq_req;
  mvd_stat_t stat;

  logic [POS_DW-1:0]  pos_rd;
  logic [TEX_DW-1:0]  tex_rd;
  logic [NRM_DW-1:0]  nrm_rd;
  logic [VERT_DW-1:0] unq_rd;

  mvd_ram #(.DW(POS_DW), .DEPTH(MAX_POSITIONS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_req.we),
    .waddr (pos_req.waddr),
    .wdata (pos_req.wdata),
    .raddr (pos_req.raddr),
    .rdata (pos_rd)
  );

  mvd_ram #(.DW(TEX_DW), .DEPTH(MAX_TEXCOORDS)) u_tex_ram (
    .clk   (clk),
    .we    (tex_req.we),
    .waddr (tex_req.waddr),
    .wdata (tex_req.wdata),
    .raddr (tex_req.raddr),
    .rdata (tex_rd)
  );

  mvd_ram #(.DW(NRM_DW), .DEPTH(MAX_NORMALS)) u_nrm_ram (
    .clk   (clk),
    .we    (nrm_req.we),
    .waddr (nrm_req.waddr),
    .wdata (nrm_req.wdata),
    .raddr (nrm_req.raddr),
    .rdata (nrm_rd)
  );

  mvd_ram #(.DW(VERT_DW), .DEPTH(MAX_UNIQUE)) u_unq_ram (
    .clk   (clk),
    .we    (unq_req.we),
    .waddr (unq_req.waddr),
    .wdata (unq_req.wdata),
    .raddr (unq_req.raddr),
    .rdata (unq_rd)
  );

  mvd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .pos_req (pos_req),
    .pos_rd  (pos_rd),
    .tex_req (tex_req),
    .tex_rd  (tex_rd),
    .nrm_req (nrm_req),
    .nrm_rd  (nrm_rd),
    .unq_req (unq_req),
    .unq_rd  (unq_rd),
    .stat    (stat)
  );

  // error results carry no slot and no create flag
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != STAT_OK) |-> (out_ch.vertex_slot == '0) && !out_ch.created)
    else $error("error result with nonzero slot or created");

  a_created_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.created |-> (out_ch.status == STAT_OK))
    else $error("created set on a failed corner");

  a_unq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stat.unique_count) <= MAX_UNIQUE)
    else $error("unique count beyond table size");

  // one item at a time: an accepted transaction makes the sequencer busy
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> stat.busy && !in_ch.ready)
    else $error("input accepted while an item is in flight");

  // the unique count only grows, and by at most one per cycle
  a_unq_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stat.unique_count == $past(stat.unique_count)) ||
                     (stat.unique_count == $past(stat.unique_count) + UNQ_CW'(1)))
    else $error("unique count stepped by more than one");

endmodule

`default_nettype wire
